### hw/rtl/cppb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cppb_pkg;

  localparam int VAL_W          = 32;
  localparam int LIM_W          = VAL_W - 1;
  localparam int FRAC_W         = 16;
  localparam int IDX_IN_W       = 3;
  localparam int LOOP_COUNT_DEF = 8;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic        [LIM_W-1:0] lim_t;
  typedef logic        [VAL_W-1:0] mag_t;
  typedef logic      [2*VAL_W-1:0] prod_t;
  typedef logic signed   [VAL_W:0] wide_t;
  typedef logic signed [VAL_W+1:0] sum_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  typedef struct packed {
    val_t gp;
    val_t gi;
    val_t gd;
    lim_t lp;
    lim_t li;
    lim_t lo;
  } cfg_ent_t;

  typedef struct packed {
    val_t prev;
    val_t integ;
  } st_ent_t;

  function automatic mag_t abs_val(val_t v);
    return v[VAL_W-1] ? (mag_t'(~v) + mag_t'(1)) : mag_t'(v);
  endfunction

  // saturate a one-bit-grown result back to the value range
  function automatic val_t sat_wide(wide_t v);
    if (v[VAL_W] != v[VAL_W-1]) begin
      return v[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return val_t'(v[VAL_W-1:0]);
  endfunction

  // drop fraction bits of a magnitude product, saturate, apply sign
  function automatic val_t qmul_finish(prod_t prod, logic neg);
    logic big;
    mag_t mag;
    big = |prod[2*VAL_W-1:FRAC_W+VAL_W-1];
    mag = {1'b0, prod[FRAC_W+VAL_W-2:FRAC_W]};
    if (big) begin
      return neg ? VAL_MIN : VAL_MAX;
    end
    return neg ? val_t'(~mag + mag_t'(1)) : val_t'(mag);
  endfunction

  function automatic val_t clamp_sym(sum_t v, lim_t lim);
    sum_t hi;
    sum_t lo;
    hi = sum_t'({1'b0, lim});
    lo = -hi;
    if (v > hi) begin
      return val_t'(hi[VAL_W-1:0]);
    end
    if (v < lo) begin
      return val_t'(lo[VAL_W-1:0]);
    end
    return val_t'(v[VAL_W-1:0]);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cppb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cppb_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [cppb_pkg::IDX_IN_W-1:0]      loop_index;
  cppb_pkg::val_t                     target;
  cppb_pkg::val_t                     measured;
  cppb_pkg::val_t                     gain_p;
  cppb_pkg::val_t                     gain_i;
  cppb_pkg::val_t                     gain_d;
  cppb_pkg::lim_t                     limit_p;
  cppb_pkg::lim_t                     limit_i;
  cppb_pkg::lim_t                     limit_out;

  modport source (
    output valid, opcode, loop_index, target, measured,
           gain_p, gain_i, gain_d, limit_p, limit_i, limit_out,
    input  ready
  );

  modport sink (
    input  valid, opcode, loop_index, target, measured,
           gain_p, gain_i, gain_d, limit_p, limit_i, limit_out,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/cppb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cppb_out_if;
  logic           valid;
  logic           ready;
  cppb_pkg::val_t drive;
  cppb_pkg::val_t term_p;
  cppb_pkg::val_t term_i;
  cppb_pkg::val_t term_d;

  modport source (
    output valid, drive, term_p, term_i, term_d,
    input  ready
  );

  modport sink (
    input  valid, drive, term_p, term_i, term_d,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/cppb_qmul.sv
`timescale 1ns / 1ps
`default_nettype none

// Q16.16 product, three stages: magnitudes, multiply, scale and saturate.
module cppb_qmul (
  input  logic           clk,
  input  logic           adv,
  input  cppb_pkg::val_t a,
  input  cppb_pkg::val_t b,
  output cppb_pkg::val_t q
);

  cppb_pkg::mag_t  a_abs_r;
  cppb_pkg::mag_t  b_abs_r;
  logic            neg_r;
  cppb_pkg::prod_t prod_r;
  logic            neg2_r;
  cppb_pkg::val_t  q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_abs_r <= cppb_pkg::abs_val(a);
      b_abs_r <= cppb_pkg::abs_val(b);
      neg_r   <= a[cppb_pkg::VAL_W-1] ^ b[cppb_pkg::VAL_W-1];
      prod_r  <= cppb_pkg::prod_t'(a_abs_r) * cppb_pkg::prod_t'(b_abs_r);
      neg2_r  <= neg_r;
      q_r     <= cppb_pkg::qmul_finish(prod_r, neg2_r);
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

### hw/rtl/cppb_gain_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Gains and limits per loop; an entry never loaded reads as zero.
module cppb_gain_store #(
  parameter int LOOP_COUNT = cppb_pkg::LOOP_COUNT_DEF,
  parameter int AW         = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [AW-1:0]      rd_idx,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_idx,
  input  cppb_pkg::cfg_ent_t wr_data,
  output cppb_pkg::cfg_ent_t rd_data
);

  cppb_pkg::cfg_ent_t    mem_r [LOOP_COUNT];
  logic [LOOP_COUNT-1:0] vld_r;
  cppb_pkg::cfg_ent_t    rd_r;
  logic                  rd_ok_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem_r[rd_idx];
    end
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (adv) begin
        rd_ok_r <= vld_r[rd_idx];
      end
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_r : '0;

endmodule

`default_nettype wire

### hw/rtl/cppb_state_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Previous error and integrator per loop. Reads are registered ahead of use;
// forward the write in progress and the write that landed with the read.
module cppb_state_store #(
  parameter int LOOP_COUNT = cppb_pkg::LOOP_COUNT_DEF,
  parameter int AW         = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [AW-1:0]     rd_idx,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_idx,
  input  cppb_pkg::st_ent_t wr_data,
  output cppb_pkg::st_ent_t rd_data
);

  cppb_pkg::st_ent_t     mem_r [LOOP_COUNT];
  logic [LOOP_COUNT-1:0] vld_r;
  cppb_pkg::st_ent_t     rd_r;
  logic                  rd_ok_r;
  logic [AW-1:0]         look_idx_r;
  logic                  wb_en_r;
  logic [AW-1:0]         wb_idx_r;
  cppb_pkg::st_ent_t     wb_data_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r       <= mem_r[rd_idx];
      look_idx_r <= rd_idx;
      wb_idx_r   <= wr_idx;
      wb_data_r  <= wr_data;
      if (wr_en) begin
        mem_r[wr_idx] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
      wb_en_r <= 1'b0;
    end else if (adv) begin
      rd_ok_r <= vld_r[rd_idx];
      wb_en_r <= wr_en;
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    priority if (wr_en && (wr_idx == look_idx_r)) begin
      rd_data = wr_data;
    end else if (wb_en_r && (wb_idx_r == look_idx_r)) begin
      rd_data = wb_data_r;
    end else if (rd_ok_r) begin
      rd_data = rd_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/clamped_positional_pid_bank_top.sv
// Throughput: one transaction per cycle, any mix of loops; the eight-stage
//   pipeline and its two memories stall as one only while the result register
//   is full and not taken and the last stage holds a finished item.
// Reset: synchronous, active low; clears pipeline valids and per-entry valid
//   bits, so every loop reads zero gains, limits and state until written.
`timescale 1ns / 1ps
`default_nettype none

module clamped_positional_pid_bank_top #(
  parameter int LOOP_COUNT = cppb_pkg::LOOP_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  cppb_in_if.sink    in_ch,
  cppb_out_if.source out_ch
);

  localparam int AW = (LOOP_COUNT > 1) ? $clog2(LOOP_COUNT) : 1;

  // One record per stage; later stages fill in the terms as they appear.
  typedef struct packed {
    logic              ok;
    cppb_pkg::op_t     op;
    logic [AW-1:0]     idx;
    cppb_pkg::val_t    err;
    cppb_pkg::val_t    gd;
    cppb_pkg::lim_t    lp;
    cppb_pkg::lim_t    li;
    cppb_pkg::lim_t    lo;
    cppb_pkg::val_t    p;
    cppb_pkg::val_t    ti;
    cppb_pkg::val_t    diff;
  } stage_t;

  logic               adv;
  logic               in_fire;
  logic               in_ok;
  logic [AW-1:0]      in_idx;
  logic [8:1]         vld_r;
  stage_t             pipe_r   [1:8];
  stage_t             pipe_nxt [1:8];

  cppb_pkg::cfg_ent_t cfg_wr;
  cppb_pkg::cfg_ent_t cfg_rd;
  logic               cfg_wr_en;
  cppb_pkg::st_ent_t  st_rd;
  cppb_pkg::st_ent_t  st_wr;
  logic               st_wr_en;

  cppb_pkg::val_t     q_p;
  cppb_pkg::val_t     q_i;
  cppb_pkg::val_t     q_d;
  cppb_pkg::sum_t     out_sum;
  cppb_pkg::val_t     out_y;
  logic               out_live;

  logic               out_valid_r;
  cppb_pkg::val_t     drive_r;
  cppb_pkg::val_t     term_p_r;
  cppb_pkg::val_t     term_i_r;
  cppb_pkg::val_t     term_d_r;

  // Advance everything unless a finished item in stage 8 has nowhere to go.
  assign adv     = !vld_r[8] || !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv && rst_n;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Indexes past the bank change nothing and return zeros.
  assign in_ok  = int'(in_ch.loop_index) < LOOP_COUNT;
  assign in_idx = AW'(in_ch.loop_index);

  // Gains and limits: written at accept by a load, read at accept by all.
  always_comb begin
    cfg_wr.gp = in_ch.gain_p;
    cfg_wr.gi = in_ch.gain_i;
    cfg_wr.gd = in_ch.gain_d;
    cfg_wr.lp = in_ch.limit_p;
    cfg_wr.li = in_ch.limit_i;
    cfg_wr.lo = in_ch.limit_out;
  end

  assign cfg_wr_en = in_fire && in_ok && (in_ch.opcode == cppb_pkg::OP_LOAD);

  cppb_gain_store #(
    .LOOP_COUNT (LOOP_COUNT),
    .AW         (AW)
  ) u_gain_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rd_idx  (in_idx),
    .wr_en   (cfg_wr_en),
    .wr_idx  (in_idx),
    .wr_data (cfg_wr),
    .rd_data (cfg_rd)
  );

  // P and I products start in stage 1 and land in stage 4.
  cppb_qmul u_qmul_p (
    .clk (clk),
    .adv (adv),
    .a   (pipe_r[1].err),
    .b   (cfg_rd.gp),
    .q   (q_p)
  );

  cppb_qmul u_qmul_i (
    .clk (clk),
    .adv (adv),
    .a   (pipe_r[1].err),
    .b   (cfg_rd.gi),
    .q   (q_i)
  );

  // Loop state: read as an item enters stage 4, written as it leaves stage 5.
  // A load writes zeros here, in order with the computes around it.
  assign st_wr_en    = vld_r[5] && pipe_r[5].ok;
  assign st_wr.prev  = (pipe_r[5].op == cppb_pkg::OP_LOAD) ? '0 : pipe_r[5].err;
  assign st_wr.integ = (pipe_r[5].op == cppb_pkg::OP_LOAD) ? '0 : pipe_r[5].ti;

  cppb_state_store #(
    .LOOP_COUNT (LOOP_COUNT),
    .AW         (AW)
  ) u_state_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rd_idx  (pipe_r[3].idx),
    .wr_en   (st_wr_en),
    .wr_idx  (pipe_r[5].idx),
    .wr_data (st_wr),
    .rd_data (st_rd)
  );

  // D product starts in stage 5 and lands in stage 8.
  cppb_qmul u_qmul_d (
    .clk (clk),
    .adv (adv),
    .a   (pipe_r[5].diff),
    .b   (pipe_r[5].gd),
    .q   (q_d)
  );

  always_comb begin
    // Stage 1: error, saturated.
    pipe_nxt[1]     = '0;
    pipe_nxt[1].ok  = in_ok;
    pipe_nxt[1].op  = cppb_pkg::op_t'(in_ch.opcode);
    pipe_nxt[1].idx = in_idx;
    pipe_nxt[1].err = cppb_pkg::sat_wide(cppb_pkg::wide_t'(in_ch.target)
                                         - cppb_pkg::wide_t'(in_ch.measured));

    // Stage 2: pick up what later stages need from the gain store.
    pipe_nxt[2]    = pipe_r[1];
    pipe_nxt[2].gd = cfg_rd.gd;
    pipe_nxt[2].lp = cfg_rd.lp;
    pipe_nxt[2].li = cfg_rd.li;
    pipe_nxt[2].lo = cfg_rd.lo;

    pipe_nxt[3] = pipe_r[2];
    pipe_nxt[4] = pipe_r[3];

    // Stage 5: clamp P, update the integrator, form the error step.
    pipe_nxt[5]      = pipe_r[4];
    pipe_nxt[5].p    = cppb_pkg::clamp_sym(cppb_pkg::sum_t'(q_p), pipe_r[4].lp);
    pipe_nxt[5].ti   = cppb_pkg::clamp_sym(
                         cppb_pkg::sum_t'(cppb_pkg::sat_wide(
                           cppb_pkg::wide_t'(st_rd.integ) + cppb_pkg::wide_t'(q_i))),
                         pipe_r[4].li);
    pipe_nxt[5].diff = cppb_pkg::sat_wide(cppb_pkg::wide_t'(pipe_r[4].err)
                                          - cppb_pkg::wide_t'(st_rd.prev));

    pipe_nxt[6] = pipe_r[5];
    pipe_nxt[7] = pipe_r[6];
    pipe_nxt[8] = pipe_r[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[7:1], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  // Final sum is exact, then clamped; loads and stray indexes return zeros.
  assign out_sum  = cppb_pkg::sum_t'(pipe_r[8].p) + cppb_pkg::sum_t'(pipe_r[8].ti)
                    + cppb_pkg::sum_t'(q_d);
  assign out_y    = cppb_pkg::clamp_sym(out_sum, pipe_r[8].lo);
  assign out_live = pipe_r[8].ok && (pipe_r[8].op == cppb_pkg::OP_COMPUTE);

  // Result register: load when stage 8 moves out, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (vld_r[8] && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[8] && adv) begin
      drive_r  <= out_live ? out_y       : '0;
      term_p_r <= out_live ? pipe_r[8].p  : '0;
      term_i_r <= out_live ? pipe_r[8].ti : '0;
      term_d_r <= out_live ? q_d          : '0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.drive  = drive_r;
  assign out_ch.term_p = term_p_r;
  assign out_ch.term_i = term_i_r;
  assign out_ch.term_d = term_d_r;

endmodule

`default_nettype wire

### tb/clamped_positional_pid_bank_top_tb.sv
`timescale 1ns / 1ps

module clamped_positional_pid_bank_top_tb;
  import cppb_pkg::*;

  localparam int     LOOPS        = LOOP_COUNT_DEF;
  localparam int     STEP_SHIFT   = FRAC_W;
  localparam int     RANDOM_STEPS = 690;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint VAL_HI       = longint'(VAL_MAX);
  localparam longint VAL_LO       = longint'(VAL_MIN);
  localparam val_t   ONE_Q        = 32'sh0001_0000;
  localparam val_t   HALF_Q       = 32'sh0000_8000;
  localparam lim_t   LIM_FULL     = '1;

  // One input transaction and one result transaction, at the port widths.
  typedef struct packed {
    op_t                 opcode;
    logic [IDX_IN_W-1:0] loop_index;
    val_t                target;
    val_t                measured;
    val_t                gain_p;
    val_t                gain_i;
    val_t                gain_d;
    lim_t                limit_p;
    lim_t                limit_i;
    lim_t                limit_out;
  } pid_step_t;

  typedef struct packed {
    val_t drive;
    val_t term_p;
    val_t term_i;
    val_t term_d;
  } pid_result_t;

  // Shadow copy of the controller bank: predicts each step's terms and holds
  // them until the matching result transaction leaves the block.
  class pid_step_checker;
    cfg_ent_t    loop_cfg   [LOOPS];
    val_t        last_err   [LOOPS];
    val_t        integ_acc  [LOOPS];
    pid_result_t expected_q [$];
    int          mismatches;

    function new();
      for (int k = 0; k < LOOPS; k++) begin
        loop_cfg[k]  = '0;
        last_err[k]  = '0;
        integ_acc[k] = '0;
      end
      mismatches = 0;
    endfunction

    static function longint saturate(longint v);
      if (v > VAL_HI) return VAL_HI;
      if (v < VAL_LO) return VAL_LO;
      return v;
    endfunction

    static function longint clamp_to(longint v, lim_t lim);
      longint l;
      l = longint'(lim);
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
    endfunction

    // Q16.16 product: magnitude truncated, so the result rounds toward zero.
    static function longint scaled_product(longint a, val_t g);
      longint b;
      longint ua;
      longint ub;
      longint m;
      logic   neg;
      b   = longint'($signed(g));
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      m   = (ua * ub) >>> STEP_SHIFT;
      return saturate(neg ? -m : m);
    endfunction

    function pid_result_t predict_step(pid_step_t s);
      int          k;
      cfg_ent_t    c;
      longint      err;
      longint      p;
      longint      i;
      longint      d;
      longint      y;
      pid_result_t res;
      k   = int'(s.loop_index);
      res = '0;
      if (s.opcode == OP_LOAD) begin
        c.gp = s.gain_p;
        c.gi = s.gain_i;
        c.gd = s.gain_d;
        c.lp = s.limit_p;
        c.li = s.limit_i;
        c.lo = s.limit_out;
        loop_cfg[k]  = c;
        last_err[k]  = '0;
        integ_acc[k] = '0;
        return res;
      end
      c   = loop_cfg[k];
      err = saturate(longint'($signed(s.target)) - longint'($signed(s.measured)));
      p   = clamp_to(scaled_product(err, c.gp), c.lp);
      i   = clamp_to(saturate(longint'($signed(integ_acc[k])) + scaled_product(err, c.gi)),
                     c.li);
      d   = scaled_product(saturate(err - longint'($signed(last_err[k]))), c.gd);
      y   = clamp_to(p + i + d, c.lo);
      last_err[k]  = val_t'(err);
      integ_acc[k] = val_t'(i);
      res.drive    = val_t'(y);
      res.term_p   = val_t'(p);
      res.term_i   = val_t'(i);
      res.term_d   = val_t'(d);
      return res;
    endfunction

    function void note_step(pid_step_t s);
      expected_q.push_back(predict_step(s));
    endfunction

    function void compare_field(string name, val_t want, val_t got);
      if (want !== got) begin
        $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(pid_result_t got);
      pid_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t ns: result expected none, actual drive %h p %h i %h d %h",
                 $time, got.drive, got.term_p, got.term_i, got.term_d);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("drive", want.drive, got.drive);
      compare_field("term_p", want.term_p, got.term_p);
      compare_field("term_i", want.term_i, got.term_i);
      compare_field("term_d", want.term_d, got.term_d);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sent_count;
  int   results_seen;
  int   sink_hold;

  pid_step_checker chk = new();

  cppb_in_if  in_ch ();
  cppb_out_if out_ch ();

  clamped_positional_pid_bank_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs or drops a transaction.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Random operands: extremes, values near zero, and anything at all.
  function automatic val_t any_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3, 4, 5: return val_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      default: return val_t'($urandom);
    endcase
  endfunction

  // Gains at least half the time within +-4.0 so that loops settle instead of saturating.
  function automatic val_t any_gain();
    case ($urandom_range(0, 9))
      0:          return VAL_MAX;
      1:          return VAL_MIN;
      2:          return '0;
      3, 4, 5, 6: return val_t'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
      default:    return val_t'($urandom);
    endcase
  endfunction

  function automatic lim_t any_limit();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return LIM_FULL;
      2, 3, 4, 5: return lim_t'($urandom_range(0, 32'h00FF_FFFF));
      default:    return lim_t'($urandom);
    endcase
  endfunction

  // Fields that the operation ignores still carry random bits.
  function automatic pid_step_t make_load(int k, val_t gp, val_t gi, val_t gd,
                                          lim_t lp, lim_t li, lim_t lo);
    pid_step_t s;
    s.opcode     = OP_LOAD;
    s.loop_index = k[IDX_IN_W-1:0];
    s.target     = val_t'($urandom);
    s.measured   = val_t'($urandom);
    s.gain_p     = gp;
    s.gain_i     = gi;
    s.gain_d     = gd;
    s.limit_p    = lp;
    s.limit_i    = li;
    s.limit_out  = lo;
    return s;
  endfunction

  function automatic pid_step_t make_compute(int k, val_t tgt, val_t meas);
    pid_step_t s;
    s.opcode     = OP_COMPUTE;
    s.loop_index = k[IDX_IN_W-1:0];
    s.target     = tgt;
    s.measured   = meas;
    s.gain_p     = val_t'($urandom);
    s.gain_i     = val_t'($urandom);
    s.gain_d     = val_t'($urandom);
    s.limit_p    = lim_t'($urandom);
    s.limit_i    = lim_t'($urandom);
    s.limit_out  = lim_t'($urandom);
    return s;
  endfunction

  function automatic pid_step_t any_load();
    return make_load($urandom_range(0, LOOPS - 1), any_gain(), any_gain(), any_gain(),
                     any_limit(), any_limit(), any_limit());
  endfunction

  // Every third block of 64 transactions goes back to back.
  function automatic int source_gap();
    if ((sent_count / 64) % 3 == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic int sink_gap();
    if ((results_seen / 48) % 3 == 1) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Present one transaction and hold it until the block takes it. Valid is
  // left high after acceptance; drop it only when the next step idles first.
  task automatic push_step(pid_step_t s);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= s.opcode;
    in_ch.loop_index <= s.loop_index;
    in_ch.target     <= s.target;
    in_ch.measured   <= s.measured;
    in_ch.gain_p     <= s.gain_p;
    in_ch.gain_i     <= s.gain_i;
    in_ch.gain_d     <= s.gain_d;
    in_ch.limit_p    <= s.limit_p;
    in_ch.limit_i    <= s.limit_i;
    in_ch.limit_out  <= s.limit_out;
    do @(posedge clk); while (!in_ch.ready);
    chk.note_step(s);
    sent_count++;
  endtask

  // Result side: take a transaction, then drop ready for a random gap, which may be zero.
  always @(posedge clk) begin : drain_results
    int          gap;
    pid_result_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      got.drive  = out_ch.drive;
      got.term_p = out_ch.term_p;
      got.term_i = out_ch.term_i;
      got.term_d = out_ch.term_d;
      chk.check_result(got);
      results_seen <= results_seen + 1;
      gap = sink_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold    <= gap;
      end
    end else if (!out_ch.ready) begin
      if (sink_hold <= 1) begin
        out_ch.ready <= 1'b1;
      end
      sink_hold <= sink_hold - 1;
    end
  end

  initial begin
    pid_step_t s;
    int        k;
    rst_n            = 1'b0;
    sent_count       = 0;
    results_seen     = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_COMPUTE;
    in_ch.loop_index = '0;
    in_ch.target     = '0;
    in_ch.measured   = '0;
    in_ch.gain_p     = '0;
    in_ch.gain_i     = '0;
    in_ch.gain_d     = '0;
    in_ch.limit_p    = '0;
    in_ch.limit_i    = '0;
    in_ch.limit_out  = '0;
    out_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Loop never loaded: zero gains and limits force zero terms, yet the
    // error is still recorded as previous error.
    push_step(make_compute(0, VAL_MAX, VAL_MIN));
    push_step(make_compute(0, '0, '0));
    // Unit gains, widest limits: error and delta saturate, sum gets clamped.
    push_step(make_load(0, ONE_Q, ONE_Q, ONE_Q, LIM_FULL, LIM_FULL, LIM_FULL));
    push_step(make_compute(0, VAL_MAX, VAL_MIN));
    push_step(make_compute(0, VAL_MIN, VAL_MAX));
    push_step(make_compute(0, VAL_MIN, VAL_MAX));
    // Extreme gains with zero limits: every clamped term is forced to zero.
    push_step(make_load(1, VAL_MIN, VAL_MAX, VAL_MIN, '0, '0, '0));
    push_step(make_compute(1, ONE_Q, -32'sh0003_0000));
    // Products far beyond 32 bits saturate to either end.
    push_step(make_load(2, VAL_MAX, VAL_MIN, VAL_MIN, LIM_FULL, LIM_FULL, LIM_FULL));
    push_step(make_compute(2, 32'sh4000_0000, -32'sh4000_0000));
    push_step(make_compute(2, -32'sh4000_0000, 32'sh4000_0000));
    // Half gains on odd errors: fractions truncate toward zero for either sign.
    push_step(make_load(3, HALF_Q, -HALF_Q, HALF_Q, LIM_FULL, LIM_FULL, LIM_FULL));
    push_step(make_compute(3, '0, 32'sh1));
    push_step(make_compute(3, 32'sh3, '0));
    push_step(make_compute(3, '0, 32'sh3));
    // Tight limits: integrator winds up against its clamp.
    push_step(make_load(4, ONE_Q, ONE_Q, '0, 31'h1, 31'h3, 31'h2));
    push_step(make_compute(4, 32'sh0005_0000, '0));
    push_step(make_compute(4, 32'sh0005_0000, '0));
    push_step(make_compute(4, -32'sh0005_0000, '0));
    // All-ones fields on the highest loop.
    push_step(make_load(LOOPS - 1, '1, '1, '1, LIM_FULL, LIM_FULL, LIM_FULL));
    push_step(make_compute(LOOPS - 1, '1, '0));
    push_step(make_compute(5, 32'sh0000_3039, -32'sh0000_1A85));

    // Give every loop a random setting, then run mostly loop steps with
    // occasional reloads. Measurements usually track the target closely.
    for (k = 0; k < LOOPS; k++) begin
      push_step(make_load(k, any_gain(), any_gain(), any_gain(),
                          any_limit(), any_limit(), any_limit()));
    end
    for (int n = 0; n < RANDOM_STEPS; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        s = any_load();
      end else begin
        s = make_compute($urandom_range(0, LOOPS - 1), any_value(), '0);
        if ($urandom_range(0, 2) != 0) begin
          s.measured = s.target - val_t'($signed($urandom_range(0, 32'h0003_FFFF))
                                         - 32'sh0002_0000);
        end else begin
          s.measured = any_value();
        end
      end
      push_step(s);
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every predicted result, then give stragglers time.
    while (chk.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0 && chk.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### clamped_positional_pid_bank_top.f
hw/rtl/cppb_pkg.sv
hw/rtl/cppb_in_if.sv
hw/rtl/cppb_out_if.sv
hw/rtl/cppb_qmul.sv
hw/rtl/cppb_gain_store.sv
hw/rtl/cppb_state_store.sv
hw/rtl/clamped_positional_pid_bank_top.sv
tb/clamped_positional_pid_bank_top_tb.sv
